// ===== design/rrd_pkg.sv =====
// Shared types, constants and operation codes for the reversible ring deque.
package rrd_pkg;

    // Ring store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef logic [2:0]               rrd_func_t;
    typedef logic [1:0]               rrd_status_t;
    typedef logic signed [WORD_W-1:0] rrd_word_t;
    typedef logic [ADDR_W-1:0]        rrd_addr_t;
    typedef logic [CNT_W-1:0]         rrd_cnt_t;

    // Operation codes
    localparam rrd_func_t FUNC_PUSH_BACK  = 3'd0;
    localparam rrd_func_t FUNC_PUSH_FRONT = 3'd1;
    localparam rrd_func_t FUNC_POP_BACK   = 3'd2;
    localparam rrd_func_t FUNC_POP_FRONT  = 3'd3;
    localparam rrd_func_t FUNC_REVERSE    = 3'd4;

    // Result status codes
    localparam rrd_status_t ST_OK    = 2'd0;
    localparam rrd_status_t ST_EMPTY = 2'd1;
    localparam rrd_status_t ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic push;       // accepted push request
        logic pop;        // accepted pop request
        logic flip;       // accepted reverse request
        logic front_req;  // request names the logical front
        logic load_out;   // move pending result into output register
    } rrd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
    } rrd_stat_t;

endpackage

// ===== design/rrd_if.sv =====
// Valid/ready channel interfaces for deque requests and results.
interface rrd_op_if;
    import rrd_pkg::*;

    logic      valid;
    logic      ready;
    rrd_func_t func;
    rrd_word_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface rrd_res_if;
    import rrd_pkg::*;

    logic        valid;
    logic        ready;
    rrd_word_t   data;
    rrd_status_t status;

    modport source (output valid, output data, output status, input ready);
    modport sink   (input valid, input data, input status, output ready);
endinterface

// ===== design/rrd_ctrl.sv =====
// Controller: request acceptance, operation decode and result hand-off.
module rrd_ctrl
    import rrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  rrd_func_t op_func,
    output logic      op_ready,
    output logic      res_valid,
    input  logic      res_ready,
    input  rrd_stat_t stat,
    output rrd_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic needs_result;
    logic out_free;

    assign op_ready  = (state_reg == S_IDLE);
    assign accept    = op_valid && op_ready;
    assign res_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || res_ready;

    // Decode the request into datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.front_req = op_func[0];
        if (accept)
        begin
            unique case (op_func)
                FUNC_PUSH_BACK, FUNC_PUSH_FRONT: cmd.push = 1'b1;
                FUNC_POP_BACK, FUNC_POP_FRONT:   cmd.pop  = 1'b1;
                FUNC_REVERSE:                    cmd.flip = 1'b1;
                default:                         ;
            endcase
        end
        cmd.load_out = (state_reg == S_RESP) && out_free;
    end

    // A pop always answers; a push answers only when rejected
    assign needs_result = cmd.pop || (cmd.push && stat.full);

    // State sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (needs_result)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/rrd_dp.sv =====
// Datapath: ring store, head/tail pointers, count, reverse flag, result register.
module rrd_dp
    import rrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rrd_cmd_t    cmd,
    input  rrd_word_t   value,
    output rrd_stat_t   stat,
    output rrd_word_t   res_data,
    output rrd_status_t res_status
);

    localparam rrd_addr_t LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam rrd_cnt_t  FULL_CNT  = CNT_W'(DEPTH);

    rrd_word_t   mem [DEPTH];

    rrd_addr_t   head_reg;
    rrd_addr_t   head_next;
    rrd_addr_t   tail_reg;
    rrd_addr_t   tail_next;
    rrd_cnt_t    count_reg;
    rrd_cnt_t    count_next;
    logic        rev_reg;
    logic        rev_next;

    rrd_word_t   rd_data_reg;
    rrd_status_t pend_status_reg;
    rrd_word_t   out_data_reg;
    rrd_status_t out_status_reg;

    logic        at_front;
    logic        wr_en;
    logic        rd_en;
    rrd_addr_t   wr_addr;
    rrd_addr_t   rd_addr;
    rrd_addr_t   head_prev;
    rrd_addr_t   head_succ;
    rrd_addr_t   tail_prev;
    rrd_addr_t   tail_succ;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

    // Reverse swaps which physical end a request names
    assign at_front = cmd.front_req ^ rev_reg;

    // Wrapping neighbor slots
    assign head_prev = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign head_succ = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_prev = (tail_reg == '0) ? LAST_SLOT : tail_reg - 1'b1;
    assign tail_succ = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;

    // Pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = '0;
        rd_addr    = at_front ? head_reg : tail_reg;

        if (cmd.push && !stat.full)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + 1'b1;
            if (stat.empty)
            begin
                head_next = '0;
                tail_next = '0;
                wr_addr   = '0;
            end
            else if (at_front)
            begin
                head_next = head_prev;
                wr_addr   = head_prev;
            end
            else
            begin
                tail_next = tail_succ;
                wr_addr   = tail_succ;
            end
        end

        if (cmd.pop && !stat.empty)
        begin
            rd_en      = 1'b1;
            count_next = count_reg - 1'b1;
            // last element leaves the pointers in place
            if (count_reg != rrd_cnt_t'(1))
            begin
                if (at_front)
                begin
                    head_next = head_succ;
                end
                else
                begin
                    tail_next = tail_prev;
                end
            end
        end

        if (cmd.flip)
        begin
            rev_next = ~rev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // Ring store, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Pending result status, captured with the request
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            pend_status_reg <= ST_FULL;
        end
        else if (cmd.pop)
        begin
            pend_status_reg <= stat.empty ? ST_EMPTY : ST_OK;
        end
    end

    // Output register; data is zero unless the pop succeeded
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg   <= (pend_status_reg == ST_OK) ? rd_data_reg : '0;
            out_status_reg <= pend_status_reg;
        end
    end

    assign res_data   = out_data_reg;
    assign res_status = out_status_reg;

endmodule

// ===== design/reversible_ring_deque_core.sv =====
// Top level of the reversible ring deque: controller plus datapath.
// A double-ended queue of 1024 signed 32-bit words in a single-port ring store.
// Each request is push back, push front, pop back, pop front or reverse; reverse
// swaps front and back for later requests without moving data. A successful push
// or a reverse gives no result. A pop, and a push refused because the store is
// full, give a result: the ring store's registered read port captures the word
// at the edge that accepts the request, and the request side then waits in the
// result state until the output register is free. A result held in the output
// register does not stop the next request from being accepted.
// Status codes: 0 ok, 1 empty on pop (data zero), 2 full on push (data zero).
// Entries of the store are undefined until written; no clearing pass is made.
module reversible_ring_deque_core
    import rrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rrd_op_if.sink    op,
    rrd_res_if.source res
);

    rrd_cmd_t  cmd;
    rrd_stat_t stat;

    rrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op.valid),
        .op_func   (op.func),
        .op_ready  (op.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (op.value),
        .stat       (stat),
        .res_data   (res.data),
        .res_status (res.status)
    );

endmodule
